/* rtl/ncc_pkg.sv */
package ncc_pkg;

  localparam int unsigned DIST_W    = 21;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DIST_W-1:0] REJECT_LIMIT_RST = 21'd999999;
  localparam logic [DIST_W-1:0] TRACK_TOL_RST    = 21'd0;

  typedef enum logic [OP_W-1:0] {
    OP_CALIBRATE = 2'd0,
    OP_CLASSIFY  = 2'd1,
    OP_TRACK     = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REJECT_LIMIT = 1'b0,
    REG_TRACK_TOL    = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ACC,
    S_DIV,
    S_WRITE,
    S_SCAN,
    S_TRACK,
    S_DRAIN,
    S_RESULT,
    S_NOP
  } ctl_state_e;

  typedef struct packed {
    logic capture;
    logic init;
    logic acc;
    logic div_step;
    logic write_ref;
    logic sq;
    logic sel_mem;
    logic emit;
    logic done_flag;
  } ncc_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_full;
    logic            scan_last;
  } ncc_sts_t;

endpackage

/* rtl/ncc_ctrl.sv */
module ncc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  ncc_pkg::ncc_sts_t sts_i,
  output ncc_pkg::ncc_cmd_t cmd_o
);
  import ncc_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_CALIBRATE: state_d = S_ACC;
          OP_CLASSIFY:  state_d = S_SCAN;
          OP_TRACK:     state_d = S_TRACK;
          default:      state_d = S_NOP;
        endcase
      end
      S_ACC: begin
        state_d = sts_i.cnt_full ? S_DIV : S_IDLE;
      end
      S_DIV:    state_d = S_WRITE;
      S_WRITE:  state_d = S_IDLE;
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_TRACK:  state_d = S_DRAIN;
      S_DRAIN:  state_d = S_RESULT;
      S_RESULT: state_d = S_IDLE;
      S_NOP:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      S_DECODE: cmd_o.init = 1'b1;
      S_ACC: begin
        cmd_o.acc  = 1'b1;
        cmd_o.emit = !sts_i.cnt_full;
      end
      S_DIV:    cmd_o.div_step = 1'b1;
      S_WRITE: begin
        cmd_o.write_ref = 1'b1;
        cmd_o.emit      = 1'b1;
        cmd_o.done_flag = 1'b1;
      end
      S_SCAN:   cmd_o.sq = 1'b1;
      S_TRACK: begin
        cmd_o.sq      = 1'b1;
        cmd_o.sel_mem = 1'b1;
      end
      S_DRAIN:  cmd_o = '0;
      S_RESULT: cmd_o.emit = 1'b1;
      S_NOP:    cmd_o.emit = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

/* rtl/ncc_datapath.sv */
module ncc_datapath #(
  parameter int unsigned SAMPLES      = 64,
  parameter int unsigned SLOTS        = 4,
  parameter int unsigned READING_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ncc_pkg::ncc_cmd_t            cmd_i,
  output ncc_pkg::ncc_sts_t            sts_o,
  input  logic                         cfg_we_i,
  input  logic [ncc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ncc_pkg::DIST_W-1:0]   cfg_data_i,
  input  logic [ncc_pkg::OP_W-1:0]     opcode_i,
  input  logic [ncc_pkg::SLOT_W-1:0]   color_slot_i,
  input  logic [READING_BITS-1:0]      red_reading_i,
  input  logic [READING_BITS-1:0]      blue_reading_i,
  output logic                         result_valid_o,
  output logic [ncc_pkg::SLOT_W-1:0]   match_index_o,
  output logic                         no_match_o,
  output logic [ncc_pkg::DIST_W-1:0]   min_distance_o,
  output logic                         lost_track_o,
  output logic                         calibration_done_o
);
  import ncc_pkg::*;

  localparam int unsigned RB   = READING_BITS;
  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned SW   = RB + $clog2(SAMPLES);
  localparam int unsigned SQW  = 2 * RB;
  localparam int unsigned XW   = (SQW + 1 > DIST_W) ? SQW + 1 : DIST_W;
  localparam int unsigned SXW  = SLOT_W + 3;
  localparam int unsigned RK   = SW + $clog2(SAMPLES);
  localparam int unsigned MW   = SW + 1;
  localparam int unsigned PW   = SW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << RK) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  // configuration
  logic [DIST_W-1:0] reject_q, tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= REJECT_LIMIT_RST;
      tol_q    <= TRACK_TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REJECT_LIMIT: reject_q <= cfg_data_i;
        REG_TRACK_TOL:    tol_q    <= cfg_data_i;
        default:          reject_q <= reject_q;
      endcase
    end
  end

  // captured item
  logic [OP_W-1:0] op_q;
  logic [IW-1:0]   slot_q;
  logic [RB-1:0]   red_q, blue_q;
  logic [SXW-1:0]  slot_ext, slot_red;

  assign slot_ext = SXW'(color_slot_i);
  assign slot_red = (slot_ext >= SXW'(SLOTS)) ? slot_ext - SXW'(SLOTS) : slot_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      slot_q <= slot_red[IW-1:0];
      red_q  <= red_reading_i;
      blue_q <= blue_reading_i;
    end
  end

  // slot scan counter
  logic [IW-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.init) begin
      step_q <= '0;
    end else if (cmd_i.sq) begin
      step_q <= step_q + 1'b1;
    end
  end

  // running sums, sample count, averages by reciprocal multiply
  logic [SW-1:0] rsum_q, bsum_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] rprod, bprod;
  logic [RB-1:0] ravg_q, bavg_q;

  assign rprod = PW'(rsum_q) * PW'(RECIP);
  assign bprod = PW'(bsum_q) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsum_q <= '0;
      bsum_q <= '0;
      ravg_q <= '0;
      bavg_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.div_step) begin
        ravg_q <= rprod[RK +: RB];
        bavg_q <= bprod[RK +: RB];
      end
      if (cmd_i.write_ref) begin
        rsum_q <= '0;
        bsum_q <= '0;
      end else if (cmd_i.acc) begin
        rsum_q <= rsum_q + SW'(red_q);
        bsum_q <= bsum_q + SW'(blue_q);
      end
      if (cmd_i.acc) begin
        cnt_q <= sts_o.cnt_full ? '0 : cnt_q + 1'b1;
      end
    end
  end

  // reference slots and remembered reference
  logic [RB-1:0] ref_red_q [SLOTS];
  logic [RB-1:0] ref_blue_q[SLOTS];
  logic [RB-1:0] mem_red_q, mem_blue_q;
  logic          found_q;
  logic [RB-1:0] cand_red_q, cand_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        ref_red_q[i]  <= '0;
        ref_blue_q[i] <= '0;
      end
    end else if (cmd_i.write_ref) begin
      ref_red_q[slot_q]  <= ravg_q;
      ref_blue_q[slot_q] <= bavg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_red_q  <= '0;
      mem_blue_q <= '0;
    end else if (cmd_i.emit && (op_q == OP_CLASSIFY) && found_q) begin
      mem_red_q  <= cand_red_q;
      mem_blue_q <= cand_blue_q;
    end
  end

  // shared distance unit, stage one: abs differences and squares
  logic [RB-1:0]  opr_red, opr_blue, dr, db;
  logic [SQW-1:0] sq_r_q, sq_b_q;
  logic [RB-1:0]  opr_red_q, opr_blue_q;
  logic [IW-1:0]  cmp_idx_q;
  logic           cmp_vld_q;

  assign opr_red  = cmd_i.sel_mem ? mem_red_q  : ref_red_q[step_q];
  assign opr_blue = cmd_i.sel_mem ? mem_blue_q : ref_blue_q[step_q];
  assign dr = (red_q >= opr_red) ? red_q - opr_red : opr_red - red_q;
  assign db = (blue_q >= opr_blue) ? blue_q - opr_blue : opr_blue - blue_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq) begin
      sq_r_q     <= SQW'(dr) * SQW'(dr);
      sq_b_q     <= SQW'(db) * SQW'(db);
      opr_red_q  <= opr_red;
      opr_blue_q <= opr_blue;
      cmp_idx_q  <= step_q;
    end
  end

  // stage two: sum and compare
  logic [XW-1:0] d, best_q, smallest_q, last_d_q;
  logic [IW-1:0] match_q;

  assign d = XW'(sq_r_q) + XW'(sq_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.sq;
      if (cmd_i.init) begin
        found_q <= 1'b0;
      end else if (cmp_vld_q && (d < best_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      best_q <= XW'(reject_q);
    end else if (cmp_vld_q) begin
      last_d_q <= d;
      if ((cmp_idx_q == '0) || (d < smallest_q)) begin
        smallest_q <= d;
      end
      if (d < best_q) begin
        best_q      <= d;
        match_q     <= cmp_idx_q;
        cand_red_q  <= opr_red_q;
        cand_blue_q <= opr_blue_q;
      end
    end
  end

  // result register
  logic                result_valid_q;
  logic [XW-1:0]       dist_sel;
  logic [SLOT_W+IW-1:0] match_ext;

  assign match_ext = (SLOT_W+IW)'(match_q);

  always_comb begin
    dist_sel = '0;
    if (op_q == OP_CLASSIFY) begin
      dist_sel = found_q ? best_q : smallest_q;
    end else if (op_q == OP_TRACK) begin
      dist_sel = last_d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      match_index_o      <= ((op_q == OP_CLASSIFY) && found_q) ?
                            match_ext[SLOT_W-1:0] : '0;
      no_match_o         <= (op_q == OP_CLASSIFY) && !found_q;
      min_distance_o     <= dist_sel[DIST_W-1:0];
      lost_track_o       <= (op_q == OP_TRACK) && (last_d_q >= XW'(tol_q));
      calibration_done_o <= cmd_i.done_flag;
    end
  end

  assign result_valid_o  = result_valid_q;
  assign sts_o.op        = op_q;
  assign sts_o.cnt_full  = (cnt_q == CW'(SAMPLES - 1));
  assign sts_o.scan_last = (step_q == IW'(SLOTS - 1));

endmodule

/* rtl/nearest_reference_color_classifier_core.sv */
// states per item: unused opcode decode, nop; ordinary calibrate sample decode, acc; the
// sample closing a calibration run decode, acc, div, write (the averages come from one
// reciprocal multiply); track decode, track, drain, result; classify decode, scan (one slot
// per cycle through one shared distance unit), drain, result; one item at a time, next item
// taken in the strobe cycle; reset clears all slots, the remembered reference, sums and count;
// reject limit 999999, tolerance 0; results last one cycle and the receiver cannot stall
module nearest_reference_color_classifier_core #(
  parameter int unsigned SAMPLES      = 64,
  parameter int unsigned SLOTS        = 4,
  parameter int unsigned READING_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [ncc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ncc_pkg::DIST_W-1:0]    cfg_data_i,
  input  logic [ncc_pkg::OP_W-1:0]      opcode_i,
  input  logic [ncc_pkg::SLOT_W-1:0]    color_slot_i,
  input  logic [READING_BITS-1:0]       red_reading_i,
  input  logic [READING_BITS-1:0]       blue_reading_i,
  output logic                          result_valid_o,
  output logic [ncc_pkg::SLOT_W-1:0]    match_index_o,
  output logic                          no_match_o,
  output logic [ncc_pkg::DIST_W-1:0]    min_distance_o,
  output logic                          lost_track_o,
  output logic                          calibration_done_o
);
  import ncc_pkg::*;

  ncc_cmd_t cmd;
  ncc_sts_t sts;

  ncc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  ncc_datapath #(
    .SAMPLES      (SAMPLES),
    .SLOTS        (SLOTS),
    .READING_BITS (READING_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .opcode_i           (opcode_i),
    .color_slot_i       (color_slot_i),
    .red_reading_i      (red_reading_i),
    .blue_reading_i     (blue_reading_i),
    .result_valid_o     (result_valid_o),
    .match_index_o      (match_index_o),
    .no_match_o         (no_match_o),
    .min_distance_o     (min_distance_o),
    .lost_track_o       (lost_track_o),
    .calibration_done_o (calibration_done_o)
  );

endmodule

/* rtl/ncc_checker.sv */
module ncc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_i,
  input logic                       result_valid_i,
  input logic [ncc_pkg::SLOT_W-1:0] match_index_i,
  input logic                       no_match_i,
  input logic [ncc_pkg::DIST_W-1:0] min_distance_i,
  input logic                       lost_track_i,
  input logic                       calibration_done_i
);
  import ncc_pkg::*;

  // the result strobe is never high back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |=> !result_valid_i)
    else $error("result strobe on two cycles in a row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> (busy_i && !result_valid_i))
    else $error("accepted item did not make the block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> !busy_i)
    else $error("result shown while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && no_match_i) |->
      (match_index_i == '0) && !lost_track_i && !calibration_done_i)
    else $error("no match mixed with other result flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && calibration_done_i) |->
      (min_distance_i == '0) && !lost_track_i && (match_index_i == '0))
    else $error("calibration result carries a distance");

endmodule

bind nearest_reference_color_classifier_core ncc_checker u_ncc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start_i),
  .busy_i             (busy_o),
  .result_valid_i     (result_valid_o),
  .match_index_i      (match_index_o),
  .no_match_i         (no_match_o),
  .min_distance_i     (min_distance_o),
  .lost_track_i       (lost_track_o),
  .calibration_done_i (calibration_done_o)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ncc_pkg::*;

  localparam int unsigned SAMPLES      = 64;
  localparam int unsigned SLOTS        = 4;
  localparam int unsigned READING_BITS = 10;
  localparam int          MAX_READING  = (1 << READING_BITS) - 1;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              miss;
    logic [DIST_W-1:0] distance;
    logic              lost;
    logic              cal_done;
  } verdict_t;

  class verdict_board;
    logic [DIST_W-1:0]       reject_lim;
    logic [DIST_W-1:0]       track_tol;
    logic [READING_BITS-1:0] ref_red [SLOTS];
    logic [READING_BITS-1:0] ref_blue [SLOTS];
    logic [READING_BITS-1:0] mem_red;
    logic [READING_BITS-1:0] mem_blue;
    logic [15:0]             red_acc;
    logic [15:0]             blue_acc;
    int unsigned             sample_cnt;
    verdict_t                pending[$];
    int unsigned             fails;

    function new();
      for (int k = 0; k < SLOTS; k++) begin
        ref_red[k]  = '0;
        ref_blue[k] = '0;
      end
      mem_red    = '0;
      mem_blue   = '0;
      red_acc    = '0;
      blue_acc   = '0;
      sample_cnt = 0;
      reject_lim = REJECT_LIMIT_RST;
      track_tol  = TRACK_TOL_RST;
      fails      = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [DIST_W-1:0] val);
      case (idx)
        REG_REJECT_LIMIT: reject_lim = val;
        REG_TRACK_TOL:    track_tol = val;
        default: ;
      endcase
    endfunction

    function logic [DIST_W-1:0] sq_gap(int r, int b, int rr, int rb);
      int dr;
      int db;
      dr = r - rr;
      db = b - rb;
      return DIST_W'(dr * dr + db * db);
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                            logic [READING_BITS-1:0] r, logic [READING_BITS-1:0] b);
      verdict_t          v;
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] best;
      logic [DIST_W-1:0] smallest;
      logic              found;
      int                k;
      v = '0;
      smallest = '0;
      case (op)
        OP_CALIBRATE: begin
          red_acc  = red_acc + r;
          blue_acc = blue_acc + b;
          sample_cnt++;
          if (sample_cnt >= SAMPLES) begin
            k = slot % SLOTS;
            ref_red[k]  = READING_BITS'(red_acc / SAMPLES);
            ref_blue[k] = READING_BITS'(blue_acc / SAMPLES);
            red_acc    = '0;
            blue_acc   = '0;
            sample_cnt = 0;
            v.cal_done = 1'b1;
          end
        end
        OP_CLASSIFY: begin
          best  = reject_lim;
          found = 1'b0;
          for (k = 0; k < SLOTS; k++) begin
            d = sq_gap(r, b, ref_red[k], ref_blue[k]);
            if (k == 0 || d < smallest) smallest = d;
            if (d < best) begin
              best   = d;
              v.slot = SLOT_W'(k);
              found  = 1'b1;
            end
          end
          if (found) begin
            mem_red    = ref_red[v.slot];
            mem_blue   = ref_blue[v.slot];
            v.distance = best;
          end else begin
            v.miss     = 1'b1;
            v.slot     = '0;
            v.distance = smallest;
          end
        end
        OP_TRACK: begin
          v.distance = sq_gap(r, b, mem_red, mem_blue);
          v.lost     = (v.distance >= track_tol);
        end
        default: ;
      endcase
      pending.push_back(v);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_verdict(logic [SLOT_W-1:0] slot, logic miss,
                                logic [DIST_W-1:0] distance, logic lost, logic cal_done);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no item waiting, expected none, actual slot %0d dist %0d",
                 $time, slot, distance);
        fails++;
        return;
      end
      want = pending.pop_front();
      compare_field("match_index", want.slot, slot);
      compare_field("no_match", want.miss, miss);
      compare_field("min_distance", want.distance, distance);
      compare_field("lost_track", want.lost, lost);
      compare_field("calibration_done", want.cal_done, cal_done);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [DIST_W-1:0]       cfg_data_i;
  logic [OP_W-1:0]         opcode_i;
  logic [SLOT_W-1:0]       color_slot_i;
  logic [READING_BITS-1:0] red_reading_i;
  logic [READING_BITS-1:0] blue_reading_i;
  logic                    result_valid_o;
  logic [SLOT_W-1:0]       match_index_o;
  logic                    no_match_o;
  logic [DIST_W-1:0]       min_distance_o;
  logic                    lost_track_o;
  logic                    calibration_done_o;

  verdict_board sb;
  bit           steady;
  int unsigned  sent;
  int unsigned  stall_cycles;

  nearest_reference_color_classifier_core #(
    .SAMPLES      (SAMPLES),
    .SLOTS        (SLOTS),
    .READING_BITS (READING_BITS)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .opcode_i           (opcode_i),
    .color_slot_i       (color_slot_i),
    .red_reading_i      (red_reading_i),
    .blue_reading_i     (blue_reading_i),
    .result_valid_o     (result_valid_o),
    .match_index_o      (match_index_o),
    .no_match_o         (no_match_o),
    .min_distance_o     (min_distance_o),
    .lost_track_o       (lost_track_o),
    .calibration_done_o (calibration_done_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_verdict(match_index_o, no_match_o, min_distance_o, lost_track_o,
                       calibration_done_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [READING_BITS-1:0] near(int base, int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > MAX_READING) v = MAX_READING;
    return v[READING_BITS-1:0];
  endfunction

  function automatic logic [READING_BITS-1:0] any_reading();
    return READING_BITS'($urandom_range(MAX_READING));
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                           logic [READING_BITS-1:0] r, logic [READING_BITS-1:0] b);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 37) gap = $urandom_range(1, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i        <= 1'b1;
    opcode_i       <= op;
    color_slot_i   <= slot;
    red_reading_i  <= r;
    blue_reading_i <= b;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(op, slot, r, b);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [DIST_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_limits(logic [DIST_W-1:0] reject, logic [DIST_W-1:0] tol);
    write_reg(REG_REJECT_LIMIT, reject);
    write_reg(REG_TRACK_TOL, tol);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // a full calibration run around one color, sometimes interrupted
  task automatic calib_run();
    int cr;
    int cb;
    int spread;
    cr = ($urandom_range(9) == 0) ? MAX_READING * int'($urandom_range(1)) : any_reading();
    cb = ($urandom_range(9) == 0) ? MAX_READING * int'($urandom_range(1)) : any_reading();
    spread = $urandom_range(40);
    do begin
      if ($urandom_range(99) < 8) begin
        send_item($urandom_range(1) ? OP_CLASSIFY : OP_TRACK, SLOT_W'($urandom_range(3)),
                  any_reading(), any_reading());
      end
      send_item(OP_CALIBRATE, SLOT_W'($urandom_range(3)), near(cr, spread), near(cb, spread));
    end while (sb.sample_cnt != 0);
  endtask

  task automatic run_phase(int unsigned n_items);
    int unsigned stop_at;
    int          k;
    int          spread;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      k = $urandom_range(99);
      if (k < 30) begin
        calib_run();
      end else if (k < 65) begin
        repeat ($urandom_range(1, 10)) begin
          k = $urandom_range(SLOTS - 1);
          case ($urandom_range(3))
            0: spread = 0;
            1: spread = 8;
            2: spread = 60;
            default: spread = 400;
          endcase
          if ($urandom_range(9) == 0) begin
            send_item(OP_CLASSIFY, SLOT_W'($urandom_range(3)), any_reading(), any_reading());
          end else begin
            send_item(OP_CLASSIFY, SLOT_W'($urandom_range(3)),
                      near(sb.ref_red[k], spread), near(sb.ref_blue[k], spread));
          end
        end
      end else if (k < 88) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(3))
            0: spread = 0;
            1: spread = 30;
            2: spread = 300;
            default: spread = MAX_READING;
          endcase
          send_item(OP_TRACK, SLOT_W'($urandom_range(3)),
                    near(sb.mem_red, spread), near(sb.mem_blue, spread));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(OP_W'($urandom_range(3)), SLOT_W'($urandom_range(3)),
                    any_reading(), any_reading());
        end
      end
    end
  endtask

  initial begin
    sb             = new();
    steady         = 1'b0;
    sent           = 0;
    stall_cycles   = 0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_REJECT_LIMIT;
    cfg_data_i     = '0;
    opcode_i       = OP_CALIBRATE;
    color_slot_i   = '0;
    red_reading_i  = '0;
    blue_reading_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all slots equal after reset, lowest slot wins the tie
    send_item(OP_CLASSIFY, 2'd0, 10'd0, 10'd0);
    send_item(OP_CLASSIFY, 2'd3, 10'd1023, 10'd1023);
    send_item(OP_CLASSIFY, 2'd1, 10'd700, 10'd0);
    send_item(OP_CLASSIFY, 2'd2, 10'd0, 10'd999);
    send_item(OP_TRACK, 2'd0, 10'd1023, 10'd1023);
    send_item(OP_TRACK, 2'd3, 10'd0, 10'd0);
    send_item(OP_TRACK, 2'd1, 10'd1023, 10'd0);
    send_item(2'd3, 2'd3, 10'd1023, 10'd1023);
    send_item(2'd3, 2'd0, 10'd0, 10'd0);
    send_item(OP_CALIBRATE, 2'd3, 10'd1023, 10'd0);
    send_item(OP_CALIBRATE, 2'd0, 10'd0, 10'd1023);
    send_item(OP_CLASSIFY, 2'd2, 10'd512, 10'd511);
    send_item(OP_CALIBRATE, 2'd2, 10'd1023, 10'd1023);
    send_item(OP_TRACK, 2'd2, 10'd341, 10'd682);
    send_item(OP_CALIBRATE, 2'd1, 10'd0, 10'd0);

    run_phase(165);
    settle();
    set_limits(21'd2093059, 21'd2093059);
    run_phase(165);
    settle();
    set_limits(21'd0, 21'd0);
    steady = 1'b1;
    run_phase(165);
    steady = 1'b0;
    settle();
    set_limits(DIST_W'($urandom_range(1000, 200000)), DIST_W'($urandom_range(100, 50000)));
    run_phase(170);
    settle();
    set_limits(REJECT_LIMIT_RST, DIST_W'($urandom_range(1, 3000)));
    run_phase(165);
    settle();

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ncc_pkg.sv
rtl/ncc_ctrl.sv
rtl/ncc_datapath.sv
rtl/nearest_reference_color_classifier_core.sv
rtl/ncc_checker.sv
tb/testbench.sv
